// ===== src/dispersive_polarization_update_core_assert.svh =====
// Assertion macros for the dispersive polarization update core.
`ifndef DISPERSIVE_POLARIZATION_UPDATE_CORE_ASSERT_SVH
`define DISPERSIVE_POLARIZATION_UPDATE_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define DPU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpu assertion failed");

// Next-cycle implication, checked outside reset.
`define DPU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpu assertion failed");

`else

`define DPU_ASSERT_IMP(label, clk, rst, ante, cons)
`define DPU_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/dpu_pkg.sv =====
// Shared types and constants for the dispersive polarization update core.
package dpu_pkg;

  localparam int DATA_W    = 32;
  localparam int COEF_W    = 32;
  localparam int FRAC_BITS = 28;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 13;
  localparam int MEM_W     = 2 * DATA_W;
  localparam int PROD_W    = DATA_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;

  localparam int NUM_CELLS_DEF = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the write port.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_STOP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C       = 3'd6;

  localparam logic MODE_DEBYE   = 1'b0;
  localparam logic MODE_LORENTZ = 1'b1;

  localparam logic [CNT_W-1:0] CELL_COUNT_RST = 13'd4096;

  typedef struct packed {
    logic                     mode;
    logic [CNT_W-1:0]         region_start;
    logic [CNT_W-1:0]         region_stop;
    logic [CNT_W-1:0]         cell_count;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]         cell_index;
    logic signed [DATA_W-1:0] field_value;
  } request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] polarization;
    logic                     was_updated;
  } result_t;

endpackage

// ===== src/dpu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dpu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dpu_cfg.sv =====
// Configuration register file of the polarization update core.
module dpu_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [dpu_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [dpu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output dpu_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= dpu_pkg::MODE_DEBYE;
      cfg.region_start <= '0;
      cfg.region_stop  <= '0;
      cfg.cell_count   <= dpu_pkg::CELL_COUNT_RST;
      cfg.coef_a       <= '0;
      cfg.coef_b       <= '0;
      cfg.coef_c       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        dpu_pkg::CFG_MODE:         cfg.mode         <= cfg_wdata[0];
        dpu_pkg::CFG_REGION_START: cfg.region_start <= cfg_wdata[dpu_pkg::CNT_W-1:0];
        dpu_pkg::CFG_REGION_STOP:  cfg.region_stop  <= cfg_wdata[dpu_pkg::CNT_W-1:0];
        dpu_pkg::CFG_CELL_COUNT:   cfg.cell_count   <= cfg_wdata[dpu_pkg::CNT_W-1:0];
        dpu_pkg::CFG_COEF_A:       cfg.coef_a       <= signed'(cfg_wdata);
        dpu_pkg::CFG_COEF_B:       cfg.coef_b       <= signed'(cfg_wdata);
        dpu_pkg::CFG_COEF_C:       cfg.coef_c       <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

endmodule

// ===== src/dpu_mac.sv =====
// Three-term multiply stage with round-half-up and saturation.
module dpu_mac (
  input  logic                             clk,
  input  dpu_pkg::cfg_t                    cfg,
  input  logic signed [dpu_pkg::DATA_W-1:0] cur,
  input  logic signed [dpu_pkg::DATA_W-1:0] prev,
  input  logic signed [dpu_pkg::DATA_W-1:0] field,
  output logic signed [dpu_pkg::DATA_W-1:0] new_val
);

  localparam int DW = dpu_pkg::DATA_W;
  localparam int SW = dpu_pkg::SUM_W;
  localparam int FB = dpu_pkg::FRAC_BITS;

  localparam logic signed [SW-1:0] HALF =
    {{(SW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic signed [DW-1:0]                m0, m1, m2;
  logic signed [dpu_pkg::PROD_W-1:0]   p0, p1, p2;
  logic signed [SW-1:0]                sum, shr;

  // Debye: a*F + b*cur. Lorentz: a*cur + b*prev + c*F.
  always_comb begin
    if (cfg.mode == dpu_pkg::MODE_LORENTZ) begin
      m0 = cur;
      m1 = prev;
      m2 = field;
    end else begin
      m0 = field;
      m1 = cur;
      m2 = '0;
    end
  end

  always_ff @(posedge clk) begin
    p0 <= cfg.coef_a * m0;
    p1 <= cfg.coef_b * m1;
    p2 <= cfg.coef_c * m2;
  end

  always_comb begin
    sum = SW'(p0) + SW'(p1) + SW'(p2) + HALF;
    shr = sum >>> FB;
    if (shr > SAT_MAX) begin
      new_val = SAT_MAX[DW-1:0];
    end else if (shr < SAT_MIN) begin
      new_val = SAT_MIN[DW-1:0];
    end else begin
      new_val = shr[DW-1:0];
    end
  end

endmodule

// ===== src/dispersive_polarization_update_core.sv =====
// Top level of the dispersive (Debye / Lorentz) polarization update core.
//
// Usage:
//   Command channel: drive request (cell index, field sample) with start; the
//   beat is taken at a rising edge with start high and busy low.
//   Result channel: done is high for exactly one cycle with result; the
//   receiver cannot stall it, so take it in that cycle.
//   Configuration: write cfg_wdata to register cfg_addr with cfg_wr_en, only
//   while no beat is in flight.
// A taken beat moves through stages A, B and C; done comes from the stage C
// register, and a beat that waits out a one-cycle stall is held in stage A.
// Throughput: one beat per cycle. The rate is set by the read-modify-write of
// the single state RAM (one read and one write port): when a beat names the
// same cell as the beat just before it, busy rises for one cycle so the
// earlier result can reach the forwarding register.
// Reset: rst is synchronous. Registers return to their defaults, then a
// clearing pass writes zero into all NUM_CELLS entries, one per cycle, with
// busy held high throughout; configuration writes are taken as usual.
// Cells at or past cell_count-1 pass through the pipeline untouched and report
// zero polarization with was_updated low.
`include "dispersive_polarization_update_core_assert.svh"

module dispersive_polarization_update_core #(
  parameter int NUM_CELLS = dpu_pkg::NUM_CELLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  dpu_pkg::request_t               request,
  output logic                            done,
  output dpu_pkg::result_t                result,
  input  logic                            cfg_wr_en,
  input  logic [dpu_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [dpu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(NUM_CELLS);
  localparam int DW = dpu_pkg::DATA_W;
  localparam int CW = dpu_pkg::CNT_W;

  dpu_pkg::cfg_t cfg;

  // Clearing pass after reset.
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Stage A: RAM read in flight, operands formed, products launched.
  logic                 a_valid, a_upd;
  logic [AW-1:0]        a_addr;
  logic signed [DW-1:0] a_field;

  // Stage B: products registered, round and saturate, RAM write.
  logic                 b_valid, b_upd;
  logic [AW-1:0]        b_addr;
  logic signed [DW-1:0] b_cur;

  // Stage C: output register, doubles as the forwarding source.
  logic                 c_valid, c_upd;
  logic [AW-1:0]        c_addr;
  logic signed [DW-1:0] c_cur, c_prev;

  logic                      accept, stall, in_upd, in_region, fwd_hit, b_write;
  logic [CW-1:0]             idx_ext;
  logic [AW-1:0]             rd_addr, wr_addr;
  logic [dpu_pkg::MEM_W-1:0] rd_word, wr_word;
  logic signed [DW-1:0]      op_cur, op_prev, new_val;

  dpu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Hold a beat in A while the beat ahead of it writes the same cell.
  assign b_write = b_valid && b_upd;
  assign stall   = a_valid && a_upd && b_write && (a_addr == b_addr);
  assign busy    = clearing || stall;
  assign accept  = start && !busy;

  // Classify the beat at the command edge.
  assign idx_ext   = CW'(request.cell_index);
  assign in_upd    = (cfg.cell_count != '0)
                  && (idx_ext < cfg.cell_count - CW'(1))
                  && (32'(request.cell_index) < NUM_CELLS);
  assign in_region = (idx_ext >= cfg.region_start) && (idx_ext < cfg.region_stop);

  // Re-read the held cell during a stall.
  assign rd_addr = stall ? a_addr : AW'(request.cell_index);

  assign wr_addr = clearing ? clr_addr : b_addr;
  assign wr_word = clearing ? '0 : {b_cur, new_val};

  dpu_ram #(
    .WIDTH (dpu_pkg::MEM_W),
    .DEPTH (NUM_CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (clearing || b_write),
    .waddr (wr_addr),
    .wdata (wr_word),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  // The write that landed on the last edge is not in the read data yet.
  assign fwd_hit = c_valid && c_upd && (c_addr == a_addr);
  assign op_cur  = fwd_hit ? c_cur  : signed'(rd_word[DW-1:0]);
  assign op_prev = fwd_hit ? c_prev : signed'(rd_word[dpu_pkg::MEM_W-1:DW]);

  dpu_mac u_mac (
    .clk     (clk),
    .cfg     (cfg),
    .cur     (op_cur),
    .prev    (op_prev),
    .field   (a_field),
    .new_val (new_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(NUM_CELLS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Control of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (!stall) begin
        a_valid <= accept;
      end
      b_valid <= a_valid && !stall;
      c_valid <= b_valid;
    end
  end

  // Payload of the pipeline.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_upd   <= in_upd;
      a_addr  <= AW'(request.cell_index);
      a_field <= in_region ? request.field_value : '0;
    end
    b_upd  <= a_upd;
    b_addr <= a_addr;
    b_cur  <= op_cur;
    c_upd  <= b_upd;
    c_addr <= b_addr;
    c_cur  <= new_val;
    c_prev <= b_cur;
  end

  assign done                = c_valid;
  assign result.polarization = c_upd ? c_cur : '0;
  assign result.was_updated  = c_upd;

  `DPU_ASSERT_NXT(a_stall_holds, clk, rst, stall, a_valid && !b_valid)
  `DPU_ASSERT_NXT(a_accept_enters, clk, rst, start && !busy, a_valid)
  `DPU_ASSERT_IMP(a_clear_no_items, clk, rst, clearing, !a_valid && !b_valid && !c_valid)
  `DPU_ASSERT_IMP(a_skip_zero, clk, rst, done && !result.was_updated,
                  result.polarization == '0)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the dispersive polarization update core.
module tb_top;

  localparam int          PIPE_LATENCY = 4;
  localparam int          CYCLE_LIMIT  = 200000;  // clearing pass plus ~1850 beats, many times over
  localparam int          PHASE_COUNT  = 12;
  localparam int          PHASE_BEATS  = 150;
  localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN        = 32'h8000_0000;
  localparam logic [31:0] Q_ONE        = 32'h1000_0000;  // 1.0 in Q4.28
  localparam logic [31:0] Q_HALF_LSB   = 32'h0800_0000;  // one half of the kept LSB

  // Scoreboard: mirror of the register file and of both polarization stores,
  // plus the results still owed by the block.
  class polarization_scoreboard;
    logic                              mode;
    logic [dpu_pkg::CNT_W-1:0]         region_start;
    logic [dpu_pkg::CNT_W-1:0]         region_stop;
    logic [dpu_pkg::CNT_W-1:0]         cell_count;
    logic signed [dpu_pkg::COEF_W-1:0] coef_a;
    logic signed [dpu_pkg::COEF_W-1:0] coef_b;
    logic signed [dpu_pkg::COEF_W-1:0] coef_c;
    logic signed [dpu_pkg::DATA_W-1:0] pol_now [dpu_pkg::NUM_CELLS_DEF];
    logic signed [dpu_pkg::DATA_W-1:0] pol_last [dpu_pkg::NUM_CELLS_DEF];
    dpu_pkg::result_t                  owed_results [$];
    int                                errors;

    function new();
      mode         = dpu_pkg::MODE_DEBYE;
      region_start = '0;
      region_stop  = '0;
      cell_count   = dpu_pkg::CELL_COUNT_RST;
      coef_a       = '0;
      coef_b       = '0;
      coef_c       = '0;
      errors       = 0;
      for (int i = 0; i < dpu_pkg::NUM_CELLS_DEF; i++) begin
        pol_now[i]  = '0;
        pol_last[i] = '0;
      end
    endfunction

    function void write_reg(logic [dpu_pkg::CFG_IDX_W-1:0] addr,
                            logic [dpu_pkg::CFG_DATA_W-1:0] data);
      case (addr)
        dpu_pkg::CFG_MODE:         mode         = data[0];
        dpu_pkg::CFG_REGION_START: region_start = data[dpu_pkg::CNT_W-1:0];
        dpu_pkg::CFG_REGION_STOP:  region_stop  = data[dpu_pkg::CNT_W-1:0];
        dpu_pkg::CFG_CELL_COUNT:   cell_count   = data[dpu_pkg::CNT_W-1:0];
        dpu_pkg::CFG_COEF_A:       coef_a       = data;
        dpu_pkg::CFG_COEF_B:       coef_b       = data;
        dpu_pkg::CFG_COEF_C:       coef_c       = data;
        default: ;
      endcase
    endfunction

    // Apply one beat to the mirrored cell and queue the polarization it owes.
    function void advance_cell(dpu_pkg::request_t beat);
      dpu_pkg::result_t                  res;
      int                                idx;
      logic signed [dpu_pkg::DATA_W-1:0] drive, cur, prv, nv;
      longint                            p0, p1, p2;
      logic signed [66:0]                acc;
      idx = int'(beat.cell_index);
      res = '0;
      // A zero count wraps to -1 here, so no cell qualifies.
      if (idx < int'(cell_count) - 1 && idx < dpu_pkg::NUM_CELLS_DEF) begin
        drive = beat.field_value;
        if (!(idx >= int'(region_start) && idx < int'(region_stop))) drive = '0;
        cur = pol_now[idx];
        prv = pol_last[idx];
        if (mode == dpu_pkg::MODE_DEBYE) begin
          p0 = longint'(coef_a) * longint'(drive);
          p1 = longint'(coef_b) * longint'(cur);
          p2 = 0;
        end else begin
          p0 = longint'(coef_a) * longint'(cur);
          p1 = longint'(coef_b) * longint'(prv);
          p2 = longint'(coef_c) * longint'(drive);
        end
        // Sum exactly in Q11.56, round half up, drop the low fraction bits, clamp.
        acc = 67'(p0) + 67'(p1) + 67'(p2) + (67'sd1 <<< (dpu_pkg::FRAC_BITS - 1));
        acc = acc >>> dpu_pkg::FRAC_BITS;
        if (acc > 67'sd2147483647) nv = Q_MAX;
        else if (acc < -67'sd2147483648) nv = Q_MIN;
        else nv = acc[dpu_pkg::DATA_W-1:0];
        pol_last[idx]    = cur;
        pol_now[idx]     = nv;
        res.polarization = nv;
        res.was_updated  = 1'b1;
      end
      owed_results.push_back(res);
    endfunction

    function void flag(string msg);
      if (errors < 10) $display("%s", msg);
      errors++;
    endfunction

    function void check_result(dpu_pkg::result_t got);
      dpu_pkg::result_t want;
      if (owed_results.size() == 0) begin
        flag($sformatf("unexpected result: pol %h updated %b", got.polarization,
                       got.was_updated));
        return;
      end
      want = owed_results.pop_front();
      if (got.polarization !== want.polarization)
        flag($sformatf("polarization: expected %h actual %h", want.polarization,
                       got.polarization));
      if (got.was_updated !== want.was_updated)
        flag($sformatf("was_updated: expected %b actual %b", want.was_updated,
                       got.was_updated));
    endfunction

    function bit clean();
      return errors == 0 && owed_results.size() == 0;
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           start     = 1'b0;
  logic                           busy;
  dpu_pkg::request_t              request   = '0;
  logic                           done;
  dpu_pkg::result_t               result;
  logic                           cfg_wr_en = 1'b0;
  logic [dpu_pkg::CFG_IDX_W-1:0]  cfg_addr  = dpu_pkg::CFG_MODE;
  logic [dpu_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  bit                    gaps_on   = 1'b1;
  int                    cycle_count = 0;
  polarization_scoreboard sb;

  dispersive_polarization_update_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Results cannot be held off: take every done cycle as it comes.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(result);
  end

  // Drive one command beat; hold start and request until the edge that takes it.
  task automatic send_beat(input dpu_pkg::request_t beat);
    while (gaps_on && $urandom_range(99) < 13) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= beat;
    do @(posedge clk); while (busy !== 1'b0);
    sb.advance_cell(beat);
  endtask

  task automatic write_reg(input logic [dpu_pkg::CFG_IDX_W-1:0] addr,
                           input logic [dpu_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(addr, data);
  endtask

  task automatic program_block(input logic md, input int rs, input int re, input int cnt,
                               input logic [31:0] ca, input logic [31:0] cb,
                               input logic [31:0] cc);
    write_reg(dpu_pkg::CFG_MODE, dpu_pkg::CFG_DATA_W'(md));
    write_reg(dpu_pkg::CFG_REGION_START, dpu_pkg::CFG_DATA_W'(rs));
    write_reg(dpu_pkg::CFG_REGION_STOP, dpu_pkg::CFG_DATA_W'(re));
    write_reg(dpu_pkg::CFG_CELL_COUNT, dpu_pkg::CFG_DATA_W'(cnt));
    write_reg(dpu_pkg::CFG_COEF_A, ca);
    write_reg(dpu_pkg::CFG_COEF_B, cb);
    write_reg(dpu_pkg::CFG_COEF_C, cc);
    cfg_wr_en <= 1'b0;
  endtask

  // Drop start, drain every owed result, then let the pipeline settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Field sample: mostly full-range, some near unity, some extremes, some tiny.
  function automatic logic [31:0] rand_field();
    case ($urandom_range(9))
      5, 6, 7: return $urandom_range(0, 32'h2000_0000) - Q_ONE;
      8: begin
        case ($urandom_range(2))
          0: return Q_MAX;
          1: return Q_MIN;
          default: return '0;
        endcase
      end
      9: return $urandom_range(0, 511) - 256;
      default: return $urandom;
    endcase
  endfunction

  // Coefficient: mostly within +/-1.0 so the stores stay in range, else anything.
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(3))
      2: return $urandom;
      3: begin
        case ($urandom_range(3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          default: return Q_ONE;
        endcase
      end
      default: return $urandom_range(0, 32'h2000_0000) - Q_ONE;
    endcase
  endfunction

  initial begin
    int          hot_base, prev_idx, rs, re, cnt, pick;
    logic [11:0] idx;
    logic        md;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: zero coefficients, empty region, full count. These beats
    // also sit behind the clearing pass until busy drops.
    send_beat('{12'd3, Q_MAX});
    send_beat('{12'd4095, Q_MIN});
    wait_idle();

    // Full-scale coefficients: saturation both ways, last cell never updated.
    program_block(dpu_pkg::MODE_DEBYE, 0, 4096, 4096, Q_MAX, Q_MIN, Q_MAX);
    send_beat('{12'd0, Q_MAX});
    send_beat('{12'd0, Q_MIN});
    send_beat('{12'd0, Q_MIN});
    send_beat('{12'd4094, Q_MAX});
    send_beat('{12'd4095, Q_MAX});
    send_beat('{12'd4095, Q_MIN});
    send_beat('{12'd1, 32'h0});
    send_beat('{12'd1, 32'h0});
    wait_idle();

    // Lorentz over a narrow region with a small count: edges of region and count.
    program_block(dpu_pkg::MODE_LORENTZ, 4, 8, 16, Q_ONE, 32'hF800_0000, Q_MAX);
    send_beat('{12'd3, Q_MAX});
    send_beat('{12'd4, Q_MAX});
    send_beat('{12'd4, Q_MIN});
    send_beat('{12'd7, 32'h1});
    send_beat('{12'd8, Q_MAX});
    send_beat('{12'd14, Q_MIN});
    send_beat('{12'd15, Q_MAX});
    send_beat('{12'd4, 32'h0});
    wait_idle();

    // Rounding: the smallest gain puts the product right at half an LSB.
    program_block(dpu_pkg::MODE_DEBYE, 20, 30, 4096, 32'h1, 32'h0, 32'h0);
    send_beat('{12'd20, Q_HALF_LSB});
    send_beat('{12'd21, -Q_HALF_LSB});
    send_beat('{12'd22, Q_HALF_LSB - 1});
    send_beat('{12'd23, -Q_HALF_LSB - 1});
    wait_idle();

    // Zero count with an inverted region, then a count of one: nothing updates.
    program_block(dpu_pkg::MODE_LORENTZ, 100, 50, 0, Q_ONE, Q_ONE, Q_ONE);
    send_beat('{12'd0, Q_MAX});
    send_beat('{12'd5, Q_MIN});
    wait_idle();
    program_block(dpu_pkg::MODE_DEBYE, 0, 0, 1, Q_ONE, Q_ONE, Q_ONE);
    send_beat('{12'd0, Q_MAX});
    wait_idle();

    // Random phases: each picks a setting, then hammers a small hot window of
    // cells so the stores build history, with back-to-back repeats to exercise
    // forwarding and a share of fully random cells.
    prev_idx = 0;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      hot_base = $urandom_range(0, 4080);
      md       = 1'($urandom_range(1));
      case ($urandom_range(3))
        0: begin
          rs = 0;
          re = 4096;
        end
        1: begin
          rs = $urandom_range(4096);
          re = $urandom_range(rs);
        end
        2: begin
          rs = $urandom_range(4096);
          re = $urandom_range(4096);
        end
        default: begin
          rs = hot_base + $urandom_range(6);
          re = rs + $urandom_range(1, 8);
        end
      endcase
      case ($urandom_range(3))
        0: cnt = 4096;
        1: cnt = $urandom_range(2, 4096);
        2: cnt = hot_base + $urandom_range(2, 16);
        default: cnt = 2;
      endcase
      program_block(md, rs, re, cnt, rand_coef(), rand_coef(), rand_coef());
      // Hold a long stretch with no gaps at all.
      gaps_on = !(p == 4 || p == 5);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        pick = $urandom_range(99);
        if (pick < 15) idx = prev_idx[11:0];
        else if (pick < 75) idx = 12'(hot_base + $urandom_range(15));
        else idx = 12'($urandom);
        prev_idx = int'(idx);
        send_beat('{idx, rand_field()});
      end
      wait_idle();
    end

    if (sb.clean()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
